// ===== src/iiee_pkg.sv =====
package iiee_pkg;

  localparam int WIDTH_DEFAULT = 32;
  localparam int CH_W          = 8;
  localparam int VALUE_W       = 32;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_START,
    PH_DIGITS,
    PH_AFTER,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } mulop_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHAR,
    CMD_FACTOR,
    CMD_STEP,
    CMD_AFTER,
    CMD_TERM,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic   needs_factor;
    logic   factor_iter;
    logic   iter_last;
    logic   last;
    logic   out_free;
    phase_t phase;
  } iiee_stat_t;

endpackage

// ===== src/iiee_if.sv =====
interface iiee_in_if import iiee_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source(output valid, ch, last, input ready);
  modport sink(input valid, ch, last, output ready);
endinterface

interface iiee_out_if import iiee_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      div_by_zero;

  modport source(output valid, value, div_by_zero, input ready);
  modport sink(input valid, value, div_by_zero, output ready);
endinterface

// ===== src/iiee_dp.sv =====
module iiee_dp import iiee_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  input  logic [CH_W-1:0]           ch,
  input  logic                      last,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_dbz,
  output iiee_stat_t                stat
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [CH_W-1:0]  ch_q;
  logic             last_q;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] prod;
  logic [WIDTH-1:0] num;
  logic             neg;
  mulop_t           mop;
  logic             addneg;
  phase_t           phase;
  logic             derr;

  // Shared shift-add multiplier / restoring divider, one bit per cycle.
  logic [WIDTH-1:0] iacc;
  logic [WIDTH-1:0] ia;
  logic [WIDTH-1:0] ib;
  logic             ineg;
  logic             idiv;
  logic [CNT_W-1:0] cnt;

  logic             is_space, is_minus, is_digit, is_muldiv, is_addsub;
  logic [WIDTH-1:0] digit_val;
  logic [WIDTH-1:0] num_x10;
  logic [WIDTH-1:0] fval;
  logic [WIDTH-1:0] sum_term;
  logic [WIDTH-1:0] prod_mag;
  logic [WIDTH-1:0] fval_mag;
  logic [WIDTH-1:0] mul_acc;
  logic [WIDTH-1:0] rem_sh;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] rem_new;
  logic [WIDTH-1:0] quo_new;
  logic [WIDTH-1:0] quo_fin;
  logic             do_after;
  logic [WIDTH+VALUE_W-1:0] sum_wide;

  always_comb begin
    is_space  = (ch_q == CH_SPACE);
    is_minus  = (ch_q == CH_MINUS);
    is_digit  = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
    is_muldiv = (ch_q == CH_STAR) || (ch_q == CH_SLASH);
    is_addsub = (ch_q == CH_PLUS) || is_minus;
    digit_val = WIDTH'(ch_q[3:0]);
    num_x10   = (num << 3) + (num << 1) + digit_val;
    fval      = neg ? (WIDTH'(0) - num) : num;
    sum_term  = addneg ? (sum - prod) : (sum + prod);
    prod_mag  = prod[WIDTH-1] ? (WIDTH'(0) - prod) : prod;
    fval_mag  = fval[WIDTH-1] ? (WIDTH'(0) - fval) : fval;

    mul_acc = iacc + (ib[0] ? ia : WIDTH'(0));
    rem_sh  = {iacc[WIDTH-2:0], ia[WIDTH-1]};
    diff    = {1'b0, rem_sh} - {1'b0, ib};
    ge      = !diff[WIDTH];
    rem_new = ge ? diff[WIDTH-1:0] : rem_sh;
    quo_new = {ia[WIDTH-2:0], ge};
    quo_fin = ineg ? (WIDTH'(0) - quo_new) : quo_new;

    do_after = (cmd == CMD_AFTER) || ((cmd == CMD_CHAR) && (phase == PH_AFTER));
    sum_wide = {VALUE_W'(0), sum};

    stat.needs_factor = ((phase == PH_START) && !is_space && !is_minus && !is_digit) ||
                        ((phase == PH_DIGITS) && !is_digit);
    stat.factor_iter  = (mop == OP_MUL) || ((mop == OP_DIV) && (num != WIDTH'(0)));
    stat.iter_last    = (cnt == CNT_W'(0));
    stat.last         = last_q;
    stat.out_free     = !out_valid || out_ready;
    stat.phase        = phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      prod      <= '0;
      num       <= '0;
      neg       <= 1'b0;
      mop       <= OP_NONE;
      addneg    <= 1'b0;
      phase     <= PH_START;
      derr      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (cmd != CMD_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        CMD_LOAD: begin
          ch_q   <= ch;
          last_q <= last;
        end
        CMD_CHAR: begin
          if (phase == PH_START) begin
            if (is_minus) begin
              neg <= !neg;
            end else if (is_digit) begin
              num   <= digit_val;
              phase <= PH_DIGITS;
            end
          end else if ((phase == PH_DIGITS) && is_digit) begin
            num <= num_x10;
          end
        end
        CMD_FACTOR: begin
          case (mop)
            OP_MUL: begin
              iacc <= '0;
              ia   <= prod;
              ib   <= fval;
              idiv <= 1'b0;
              cnt  <= CNT_W'(WIDTH - 1);
            end
            OP_DIV: begin
              if (num == WIDTH'(0)) begin
                derr  <= 1'b1;
                prod  <= '0;
                num   <= '0;
                neg   <= 1'b0;
                phase <= PH_AFTER;
              end else begin
                iacc <= '0;
                ia   <= prod_mag;
                ib   <= fval_mag;
                ineg <= prod[WIDTH-1] ^ fval[WIDTH-1];
                idiv <= 1'b1;
                cnt  <= CNT_W'(WIDTH - 1);
              end
            end
            default: begin
              prod  <= fval;
              num   <= '0;
              neg   <= 1'b0;
              phase <= PH_AFTER;
            end
          endcase
        end
        CMD_STEP: begin
          cnt <= cnt - CNT_W'(1);
          if (idiv) begin
            iacc <= rem_new;
            ia   <= quo_new;
          end else begin
            iacc <= mul_acc;
            ia   <= ia << 1;
            ib   <= ib >> 1;
          end
          if (cnt == CNT_W'(0)) begin
            prod  <= idiv ? quo_fin : mul_acc;
            num   <= '0;
            neg   <= 1'b0;
            phase <= PH_AFTER;
          end
        end
        CMD_TERM: begin
          sum  <= sum_term;
          prod <= '0;
          mop  <= OP_NONE;
        end
        CMD_EMIT: begin
          out_valid <= 1'b1;
          out_value <= derr ? '0 : sum_wide[VALUE_W-1:0];
          out_dbz   <= derr;
          sum       <= '0;
          prod      <= '0;
          num       <= '0;
          neg       <= 1'b0;
          mop       <= OP_NONE;
          addneg    <= 1'b0;
          phase     <= PH_START;
          derr      <= 1'b0;
        end
        default: begin
        end
      endcase
      // A character that follows a finished factor: blanks are skipped,
      // operators set up the next factor or term, anything else stops.
      if (do_after && !is_space) begin
        if (is_muldiv) begin
          mop   <= (ch_q == CH_STAR) ? OP_MUL : OP_DIV;
          phase <= PH_START;
        end else begin
          sum  <= sum_term;
          prod <= '0;
          mop  <= OP_NONE;
          if (is_addsub) begin
            addneg <= is_minus;
            phase  <= PH_START;
          end else begin
            phase <= PH_STOP;
          end
        end
      end
    end
  end

endmodule

// ===== src/iiee_ctrl.sv =====
module iiee_ctrl import iiee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  iiee_stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_FACTOR,
    S_ITER,
    S_AFTER,
    S_END,
    S_TERM,
    S_EMIT
  } state_t;

  state_t state;
  logic   cont_after;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:   cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_CHAR:   cmd = CMD_CHAR;
      S_FACTOR: cmd = CMD_FACTOR;
      S_ITER:   cmd = CMD_STEP;
      S_AFTER:  cmd = CMD_AFTER;
      S_TERM:   cmd = CMD_TERM;
      S_EMIT:   cmd = stat.out_free ? CMD_EMIT : CMD_NONE;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cont_after <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHAR;
          end
        end
        S_CHAR: begin
          if (stat.needs_factor) begin
            cont_after <= 1'b1;
            state      <= S_FACTOR;
          end else begin
            state <= stat.last ? S_END : S_IDLE;
          end
        end
        S_FACTOR: begin
          if (stat.factor_iter) begin
            state <= S_ITER;
          end else begin
            state <= cont_after ? S_AFTER : S_TERM;
          end
        end
        S_ITER: begin
          if (stat.iter_last) begin
            state <= cont_after ? S_AFTER : S_TERM;
          end
        end
        S_AFTER: begin
          state <= stat.last ? S_END : S_IDLE;
        end
        S_END: begin
          // The line may end inside a factor; finish it before the last term.
          case (stat.phase)
            PH_START, PH_DIGITS: begin
              cont_after <= 1'b0;
              state      <= S_FACTOR;
            end
            PH_AFTER: state <= S_TERM;
            default:  state <= S_EMIT;
          endcase
        end
        S_TERM: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/infix_integer_expression_evaluator.sv =====
// Channel  Dir  Payload                          Handshake
// expr     in   ch[7:0], last                    valid / ready
// result   out  value[31:0] signed, div_by_zero  valid / ready
//
// One character at a time: a new character is taken only once the last is through. A character that
// ends a factor also runs the factor step; after star, or slash with a nonzero divisor, the
// shared bit-serial multiply/divide unit then computes the product or quotient bit by bit.
// The last character of a line also closes any open factor and term before the result.
// Synchronous reset returns the parser to the start of a line.
// A held result stalls the block only when the next line's result is ready.
module infix_integer_expression_evaluator import iiee_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  iiee_in_if.sink    expr,
  iiee_out_if.source result
);

  cmd_t       cmd;
  iiee_stat_t stat;

  iiee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (expr.valid),
    .in_ready (expr.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iiee_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ch        (expr.ch),
    .last      (expr.last),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_value (result.value),
    .out_dbz   (result.div_by_zero),
    .stat      (stat)
  );

endmodule

// ===== verif/iiee_result_check.sv =====
`timescale 1ns / 100ps

module iiee_result_check import iiee_pkg::*; (
  input  logic clk,
  input  logic rst,
  iiee_in_if   expr,
  iiee_out_if  result,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               div_by_zero;
  } expr_result_t;

  expr_result_t expected_q[$];

  // Evaluator state for the line currently being received.
  logic [VALUE_W-1:0] sum_r;
  logic [VALUE_W-1:0] prod_r;
  logic [VALUE_W-1:0] num_r;
  logic               neg_r;
  mulop_t             mul_op_r;
  logic               sub_r;
  phase_t             ph_r;
  logic               dbz_r;

  function automatic logic [VALUE_W-1:0] magnitude(input logic [VALUE_W-1:0] x);
    return x[VALUE_W-1] ? -x : x;
  endfunction

  task automatic clear_line();
    sum_r    = '0;
    prod_r   = '0;
    num_r    = '0;
    neg_r    = 1'b0;
    mul_op_r = OP_NONE;
    sub_r    = 1'b0;
    ph_r     = PH_START;
    dbz_r    = 1'b0;
  endtask

  task automatic close_factor();
    logic [VALUE_W-1:0] f;
    logic [VALUE_W-1:0] q;
    f = neg_r ? -num_r : num_r;
    case (mul_op_r)
      OP_MUL: prod_r = prod_r * f;
      OP_DIV: begin
        if (f == '0) begin
          dbz_r  = 1'b1;
          prod_r = '0;
        end else begin
          // Unsigned divide of magnitudes, then fix the sign: truncates toward zero.
          q      = magnitude(prod_r) / magnitude(f);
          prod_r = (prod_r[VALUE_W-1] ^ f[VALUE_W-1]) ? -q : q;
        end
      end
      default: prod_r = f;
    endcase
    num_r = '0;
    neg_r = 1'b0;
    ph_r  = PH_AFTER;
  endtask

  task automatic close_term();
    sum_r    = sub_r ? sum_r - prod_r : sum_r + prod_r;
    prod_r   = '0;
    mul_op_r = OP_NONE;
  endtask

  task automatic after_factor(input logic [CH_W-1:0] c);
    if (c == CH_SPACE) begin
      return;
    end
    if (c == CH_STAR || c == CH_SLASH) begin
      mul_op_r = (c == CH_STAR) ? OP_MUL : OP_DIV;
      ph_r     = PH_START;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      close_term();
      sub_r = (c == CH_MINUS);
      ph_r  = PH_START;
    end else begin
      close_term();
      ph_r = PH_STOP;
    end
  endtask

  task automatic take_char(input logic [CH_W-1:0] c);
    logic               is_digit;
    logic [VALUE_W-1:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = VALUE_W'(c - CH_ZERO);
    case (ph_r)
      PH_START: begin
        if (c == CH_MINUS) begin
          neg_r = ~neg_r;
        end else if (is_digit) begin
          num_r = d;
          ph_r  = PH_DIGITS;
        end else if (c != CH_SPACE) begin
          close_factor();
          after_factor(c);
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          num_r = num_r * 10 + d;
        end else begin
          close_factor();
          after_factor(c);
        end
      end
      PH_AFTER: after_factor(c);
      default: ;
    endcase
  endtask

  task automatic take_item(input logic [CH_W-1:0] c, input logic l);
    expr_result_t res;
    take_char(c);
    if (l) begin
      // A line that ends inside a factor finishes it as if a stop followed.
      if (ph_r == PH_START || ph_r == PH_DIGITS) close_factor();
      if (ph_r == PH_AFTER) close_term();
      res.value       = dbz_r ? '0 : sum_r;
      res.div_by_zero = dbz_r;
      expected_q.insert(expected_q.size(), res);
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    int           n_err;
    expr_result_t want;
    n_err = 0;
    if (rst) begin
      clear_line();
      expected_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: value=%0d div_by_zero=%0b",
                 result.value, result.div_by_zero);
          n_err++;
        end else begin
          want = expected_q.pop_front();
          if (result.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(want.value), result.value);
            n_err++;
          end
          if (result.div_by_zero !== want.div_by_zero) begin
            $error("div_by_zero mismatch: expected %0b, actual %0b",
                   want.div_by_zero, result.div_by_zero);
            n_err++;
          end
        end
      end
      if (expr.valid && expr.ready) begin
        take_item(expr.ch, expr.last);
      end
    end
    errors      <= rst ? 0 : errors + n_err;
    outstanding <= expected_q.size();
  end

endmodule

// ===== verif/tb_infix_integer_expression_evaluator.sv =====
`timescale 1ns / 100ps

module tb_infix_integer_expression_evaluator;
  import iiee_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = WIDTH_DEFAULT + 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int expected_left;
  int src_idle_pct  = 0;
  int dst_stall_pct = 0;
  int random_items  = 0;
  int quiet_cycles  = 0;

  logic [CH_W-1:0] line_q[$];

  iiee_in_if  expr_ch();
  iiee_out_if result_ch();

  infix_integer_expression_evaluator dut (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr_ch),
    .result (result_ch)
  );

  iiee_result_check result_check (
    .clk         (clk),
    .rst         (rst),
    .expr        (expr_ch),
    .result      (result_ch),
    .errors      (fail_count),
    .outstanding (expected_left)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    result_ch.ready <= (dst_stall_pct == 0) || ($urandom_range(99) >= dst_stall_pct);
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (expr_ch.valid && expr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [CH_W-1:0] c, input logic l);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      expr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    expr_ch.valid <= 1'b1;
    expr_ch.ch    <= c;
    expr_ch.last  <= l;
    @(posedge clk);
    while (!expr_ch.ready) @(posedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      send_item(line_q[i], i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  task automatic append_char(input logic [CH_W-1:0] c);
    line_q.insert(line_q.size(), c);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  task automatic add_blanks();
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0) append_char(CH_SPACE);
  endtask

  function automatic logic [CH_W-1:0] pick_op();
    case ($urandom_range(3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  // Mostly well-formed expressions with random content; the rest is raw
  // noise, factors without digits, trailing operators and trailing junk.
  task automatic build_line();
    int kind;
    int n_terms;
    int n_digits;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) append_char(CH_W'($urandom_range(255)));
      return;
    end
    n_terms = $urandom_range(1, 6);
    for (int i = 0; i < n_terms; i++) begin
      if (i > 0) begin
        add_blanks();
        append_char(pick_op());
      end
      add_blanks();
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0) begin
        append_char(CH_MINUS);
        add_blanks();
      end
      n_digits = ($urandom_range(15) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 3);
      if (kind < 16 && $urandom_range(2) == 0) n_digits = 0;
      for (int k = 0; k < n_digits; k++) begin
        append_char(CH_ZERO + CH_W'((k == 0 && $urandom_range(7) != 0) ?
                                    $urandom_range(1, 9) : $urandom_range(9)));
      end
    end
    add_blanks();
    if (kind >= 16 && kind < 20) begin
      append_char(pick_op());
    end else if (kind >= 20 && kind < 24) begin
      repeat ($urandom_range(1, 5)) append_char(CH_W'($urandom_range(255)));
    end
    if (line_q.size() == 0) append_char(CH_ZERO);
  endtask

  initial begin
    expr_ch.valid   = 1'b0;
    expr_ch.ch      = '0;
    expr_ch.last    = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Most negative value over minus one, division by zero, a trailing
    // operator followed by a top-bit character, and a lone NUL.
    push_str("2147483648/-1");
    send_line();
    push_str("6/0-4");
    send_line();
    push_str("3*4+");
    append_char(8'hFF);
    send_line();
    append_char(8'h00);
    send_line();

    while (random_items < ITEM_TARGET) begin
      case (random_items * 4 / ITEM_TARGET)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 49; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 49; end
        default: begin src_idle_pct = 24; dst_stall_pct = 24; end
      endcase
      build_line();
      random_items += line_q.size();
      send_line();
    end

    expr_ch.valid <= 1'b0;
    dst_stall_pct = 0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/iiee_pkg.sv
src/iiee_if.sv
src/iiee_dp.sv
src/iiee_ctrl.sv
src/infix_integer_expression_evaluator.sv
verif/iiee_result_check.sv
verif/tb_infix_integer_expression_evaluator.sv
